// File: design/qrv_pkg.sv
// qrv_pkg: shared types and fixed-point constants for the quaternion rotation block
`timescale 1ns / 1ps

package qrv_pkg;

   localparam int QUAT_WIDTH  = 16;
   localparam int PROD_WIDTH  = 2 * QUAT_WIDTH;
   localparam int MAT_WIDTH   = PROD_WIDTH + 2;
   localparam int QUAT_FRAC   = 14;
   localparam int ROUND_SHIFT = 2 * QUAT_FRAC;
   localparam int NUM_AXES    = 3;
   localparam int NUM_MAT     = NUM_AXES * NUM_AXES;

   typedef logic signed [QUAT_WIDTH-1:0] quat_comp_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [MAT_WIDTH-1:0]  mat_elem_type;

   typedef struct packed {
      quat_comp_type w;
      quat_comp_type x;
      quat_comp_type y;
      quat_comp_type z;
   } quat_type;

endpackage

// File: design/qrv_if.sv
// qrv_if: request and response channel interfaces of the quaternion rotation block
`timescale 1ns / 1ps

interface qrv_req_if #(parameter int DATA_WIDTH = 16);
   import qrv_pkg::*;

   logic                          valid;
   logic                          ready;
   quat_comp_type                 quat_w;
   quat_comp_type                 quat_x;
   quat_comp_type                 quat_y;
   quat_comp_type                 quat_z;
   logic signed [DATA_WIDTH-1:0]  vec_x;
   logic signed [DATA_WIDTH-1:0]  vec_y;
   logic signed [DATA_WIDTH-1:0]  vec_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                   input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                   output ready);
endinterface

interface qrv_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  rot_x;
   logic signed [DATA_WIDTH-1:0]  rot_y;
   logic signed [DATA_WIDTH-1:0]  rot_z;
   logic                          saturated;

   modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
   modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

// File: design/qrv_matrix.sv
// qrv_matrix: quaternion products and rotation matrix, two pipeline stages
`timescale 1ns / 1ps

module qrv_matrix #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  qrv_pkg::quat_type             quat,
   input  logic signed [DATA_WIDTH-1:0]  vec [qrv_pkg::NUM_AXES],
   output logic                          out_valid,
   input  logic                          out_ready,
   output qrv_pkg::mat_elem_type         mat [qrv_pkg::NUM_MAT],
   output logic signed [DATA_WIDTH-1:0]  vec_out [qrv_pkg::NUM_AXES]
);
   import qrv_pkg::*;

   logic en_a, en_b;
   logic va_ff, va_in, vb_ff, vb_in;

   prod_type ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   prod_type ww_in, xx_in, yy_in, zz_in, xy_in, xz_in, yz_in, wx_in, wy_in, wz_in;
   logic signed [DATA_WIDTH-1:0] veca_ff [NUM_AXES];
   logic signed [DATA_WIDTH-1:0] vecb_ff [NUM_AXES];
   mat_elem_type mat_ff [NUM_MAT];
   mat_elem_type mat_in [NUM_MAT];

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;
   assign va_in    = en_a ? in_valid : va_ff;
   assign vb_in    = en_b ? va_ff : vb_ff;

   // stage a: the ten component products
   assign ww_in = PROD_WIDTH'(quat.w) * PROD_WIDTH'(quat.w);
   assign xx_in = PROD_WIDTH'(quat.x) * PROD_WIDTH'(quat.x);
   assign yy_in = PROD_WIDTH'(quat.y) * PROD_WIDTH'(quat.y);
   assign zz_in = PROD_WIDTH'(quat.z) * PROD_WIDTH'(quat.z);
   assign xy_in = PROD_WIDTH'(quat.x) * PROD_WIDTH'(quat.y);
   assign xz_in = PROD_WIDTH'(quat.x) * PROD_WIDTH'(quat.z);
   assign yz_in = PROD_WIDTH'(quat.y) * PROD_WIDTH'(quat.z);
   assign wx_in = PROD_WIDTH'(quat.w) * PROD_WIDTH'(quat.x);
   assign wy_in = PROD_WIDTH'(quat.w) * PROD_WIDTH'(quat.y);
   assign wz_in = PROD_WIDTH'(quat.w) * PROD_WIDTH'(quat.z);

   // stage b: matrix entries, row major
   always_comb begin
      mat_in[0] = MAT_WIDTH'(ww_ff) + MAT_WIDTH'(xx_ff) - MAT_WIDTH'(yy_ff) - MAT_WIDTH'(zz_ff);
      mat_in[1] = (MAT_WIDTH'(xy_ff) - MAT_WIDTH'(wz_ff)) <<< 1;
      mat_in[2] = (MAT_WIDTH'(xz_ff) + MAT_WIDTH'(wy_ff)) <<< 1;
      mat_in[3] = (MAT_WIDTH'(xy_ff) + MAT_WIDTH'(wz_ff)) <<< 1;
      mat_in[4] = MAT_WIDTH'(ww_ff) - MAT_WIDTH'(xx_ff) + MAT_WIDTH'(yy_ff) - MAT_WIDTH'(zz_ff);
      mat_in[5] = (MAT_WIDTH'(yz_ff) - MAT_WIDTH'(wx_ff)) <<< 1;
      mat_in[6] = (MAT_WIDTH'(xz_ff) - MAT_WIDTH'(wy_ff)) <<< 1;
      mat_in[7] = (MAT_WIDTH'(yz_ff) + MAT_WIDTH'(wx_ff)) <<< 1;
      mat_in[8] = MAT_WIDTH'(ww_ff) - MAT_WIDTH'(xx_ff) - MAT_WIDTH'(yy_ff) + MAT_WIDTH'(zz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
      if (en_a && in_valid) begin
         ww_ff   <= ww_in;
         xx_ff   <= xx_in;
         yy_ff   <= yy_in;
         zz_ff   <= zz_in;
         xy_ff   <= xy_in;
         xz_ff   <= xz_in;
         yz_ff   <= yz_in;
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
         wz_ff   <= wz_in;
         veca_ff <= vec;
      end
      if (en_b && va_ff) begin
         mat_ff  <= mat_in;
         vecb_ff <= veca_ff;
      end
   end

   assign out_valid = vb_ff;
   assign mat       = mat_ff;
   assign vec_out   = vecb_ff;

   // a stall reaches the input only when both stages hold a word
   assert property (@(posedge clock) disable iff (reset) !in_ready |-> (va_ff && vb_ff))
      else $error("qrv_matrix stalled with an empty stage");

endmodule

// File: design/qrv_dot.sv
// qrv_dot: matrix by vector products and rounded row sums, two pipeline stages
`timescale 1ns / 1ps

module qrv_dot #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  qrv_pkg::mat_elem_type         mat [qrv_pkg::NUM_MAT],
   input  logic signed [DATA_WIDTH-1:0]  vec [qrv_pkg::NUM_AXES],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [DATA_WIDTH+qrv_pkg::MAT_WIDTH+1-qrv_pkg::ROUND_SHIFT:0]
                                         rnd [qrv_pkg::NUM_AXES]
);
   import qrv_pkg::*;

   localparam int PRODW = MAT_WIDTH + DATA_WIDTH;
   localparam int SUMW  = PRODW + 2;
   localparam int RNDW  = SUMW - ROUND_SHIFT;
   localparam logic signed [SUMW-1:0] RoundHalf = SUMW'(1) <<< (ROUND_SHIFT - 1);

   logic en_c, en_d;
   logic vc_ff, vc_in, vd_ff, vd_in;

   logic signed [PRODW-1:0] prd_ff [NUM_MAT];
   logic signed [PRODW-1:0] prd_in [NUM_MAT];
   logic signed [SUMW-1:0]  sum    [NUM_AXES];
   logic signed [RNDW-1:0]  rnd_ff [NUM_AXES];
   logic signed [RNDW-1:0]  rnd_in [NUM_AXES];

   assign en_d     = !vd_ff || out_ready;
   assign en_c     = !vc_ff || en_d;
   assign in_ready = en_c;
   assign vc_in    = en_c ? in_valid : vc_ff;
   assign vd_in    = en_d ? vc_ff : vd_ff;

   for (genvar i = 0; i < NUM_MAT; i++) begin : g_prod
      assign prd_in[i] = PRODW'(mat[i]) * PRODW'(vec[i % NUM_AXES]);
   end

   // round half up by the q6.28 scale of the matrix entries
   for (genvar r = 0; r < NUM_AXES; r++) begin : g_row
      assign sum[r] = SUMW'(prd_ff[NUM_AXES*r]) + SUMW'(prd_ff[NUM_AXES*r+1])
                    + SUMW'(prd_ff[NUM_AXES*r+2]) + RoundHalf;
      assign rnd_in[r] = sum[r][SUMW-1:ROUND_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         vc_ff <= vc_in;
         vd_ff <= vd_in;
      end
      if (en_c && in_valid) begin
         prd_ff <= prd_in;
      end
      if (en_d && vc_ff) begin
         rnd_ff <= rnd_in;
      end
   end

   assign out_valid = vd_ff;
   assign rnd       = rnd_ff;

   assert property (@(posedge clock) disable iff (reset) !in_ready |-> (vc_ff && vd_ff))
      else $error("qrv_dot stalled with an empty stage");

endmodule

// File: design/qrv_sat.sv
// qrv_sat: saturation to the output width and the output register
`timescale 1ns / 1ps

module qrv_sat #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [DATA_WIDTH+qrv_pkg::MAT_WIDTH+1-qrv_pkg::ROUND_SHIFT:0]
                                         rnd [qrv_pkg::NUM_AXES],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [DATA_WIDTH-1:0]  rot [qrv_pkg::NUM_AXES],
   output logic                          saturated
);
   import qrv_pkg::*;

   localparam int RNDW = DATA_WIDTH + MAT_WIDTH + 2 - ROUND_SHIFT;
   localparam logic [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic en_e;
   logic ve_ff, ve_in;
   logic signed [DATA_WIDTH-1:0] rot_ff [NUM_AXES];
   logic signed [DATA_WIDTH-1:0] rot_in [NUM_AXES];
   logic                         sat_ff, sat_in;
   logic [NUM_AXES-1:0]          clip;

   assign en_e     = !ve_ff || out_ready;
   assign in_ready = en_e;
   assign ve_in    = en_e ? in_valid : ve_ff;

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         clip[a] = !((&rnd[a][RNDW-1:DATA_WIDTH-1]) || !(|rnd[a][RNDW-1:DATA_WIDTH-1]));
         if (clip[a]) begin
            rot_in[a] = rnd[a][RNDW-1] ? MinVal : MaxVal;
         end else begin
            rot_in[a] = rnd[a][DATA_WIDTH-1:0];
         end
      end
      sat_in = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else begin
         ve_ff <= ve_in;
      end
      if (en_e && in_valid) begin
         rot_ff <= rot_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = ve_ff;
   assign rot       = rot_ff;
   assign saturated = sat_ff;

endmodule

// File: design/quaternion_rotate_vector_top.sv
// quaternion_rotate_vector_top: rotates a vector by a quaternion, q * (0,v) * conj(q)
`timescale 1ns / 1ps
//
// request channel (req_chan): one word holds a q2.14 quaternion w, x, y, z and a
// signed integer vector x, y, z of DATA_WIDTH bits. the quaternion is not
// normalised, so a non-unit quaternion also scales the vector by |q|^2.
// response channel (rsp_chan): one word per request word, in order, holding the
// rotated vector rounded half up and clipped to DATA_WIDTH bits, with saturated
// set when any component was clipped.
// the pipeline has five register stages: component products, matrix entries,
// matrix by vector products, rounded row sums, clipping and output register.
// a word accepted on req_chan passes the stage registers in order before
// rsp_chan shows it; throughput is one word per cycle while rsp_chan.ready is high.
// when the receiver stalls, each stage keeps its word and empty stages still
// fill; req_chan.ready falls only once all five stages hold a word.
// req_chan.ready follows rsp_chan.ready combinationally through the stages.
// reset (synchronous, active high) empties the pipeline; no state is kept
// between words.
//
module quaternion_rotate_vector_top #(
   parameter int DATA_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   qrv_req_if.sink    req_chan,
   qrv_rsp_if.source  rsp_chan
);
   import qrv_pkg::*;

   localparam int RNDW = DATA_WIDTH + MAT_WIDTH + 2 - ROUND_SHIFT;

   quat_type                     quat;
   logic signed [DATA_WIDTH-1:0] vec_in  [NUM_AXES];
   logic signed [DATA_WIDTH-1:0] vec_mat [NUM_AXES];
   mat_elem_type                 mat     [NUM_MAT];
   logic signed [RNDW-1:0]       rnd     [NUM_AXES];
   logic signed [DATA_WIDTH-1:0] rot     [NUM_AXES];

   logic mat_valid, mat_ready;
   logic dot_valid, dot_ready;

   assign quat.w    = req_chan.quat_w;
   assign quat.x    = req_chan.quat_x;
   assign quat.y    = req_chan.quat_y;
   assign quat.z    = req_chan.quat_z;
   assign vec_in[0] = req_chan.vec_x;
   assign vec_in[1] = req_chan.vec_y;
   assign vec_in[2] = req_chan.vec_z;

   qrv_matrix #(.DATA_WIDTH(DATA_WIDTH)) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .quat      (quat),
      .vec       (vec_in),
      .out_valid (mat_valid),
      .out_ready (mat_ready),
      .mat       (mat),
      .vec_out   (vec_mat)
   );

   qrv_dot #(.DATA_WIDTH(DATA_WIDTH)) u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_ready  (mat_ready),
      .mat       (mat),
      .vec       (vec_mat),
      .out_valid (dot_valid),
      .out_ready (dot_ready),
      .rnd       (rnd)
   );

   qrv_sat #(.DATA_WIDTH(DATA_WIDTH)) u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .in_ready  (dot_ready),
      .rnd       (rnd),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .rot       (rot),
      .saturated (rsp_chan.saturated)
   );

   assign rsp_chan.rot_x = rot[0];
   assign rsp_chan.rot_y = rot[1];
   assign rsp_chan.rot_z = rot[2];

   // back pressure on the request side only comes from a waiting response
   assert property (@(posedge clock) disable iff (reset) !req_chan.ready |-> rsp_chan.valid)
      else $error("request stalled with no response waiting");

   // a clipped word has at least one component at a bound
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.saturated) |->
         (rsp_chan.rot_x == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
          rsp_chan.rot_x == {1'b1, {(DATA_WIDTH-1){1'b0}}} ||
          rsp_chan.rot_y == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
          rsp_chan.rot_y == {1'b1, {(DATA_WIDTH-1){1'b0}}} ||
          rsp_chan.rot_z == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
          rsp_chan.rot_z == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
      else $error("saturated flag set with no component at a bound");

endmodule

// File: tb/tb_quaternion_rotate_vector_top.sv
// testbench: quaternion rotation of a vector against its own predictor, with directed and random words
`timescale 1ns / 1ps

module tb_quaternion_rotate_vector_top;
   import qrv_pkg::*;

   localparam int DATA_WIDTH   = 16;
   localparam int RANDOM_WORDS = 1950;
   localparam int STALL_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 400000;

   typedef logic signed [DATA_WIDTH-1:0] comp_type;

   typedef struct packed {
      quat_type q;
      comp_type vx;
      comp_type vy;
      comp_type vz;
   } vec_word_type;

   typedef struct packed {
      comp_type rot_x;
      comp_type rot_y;
      comp_type rot_z;
      logic     saturated;
   } rot_word_type;

   typedef struct {
      vec_word_type word;
      bit           known;
      rot_word_type want;
   } table_row_type;

   logic clock;
   logic reset;

   qrv_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_chan ();
   qrv_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_chan ();

   quaternion_rotate_vector_top #(.DATA_WIDTH(DATA_WIDTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rot_word_type  rotations_due [$];
   table_row_type directed_rows [$];
   int            failures;
   int            cycle_count;
   bit            steady_flow;
   bit            stall_wanted;
   bit            stall_done;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // rotated vector: rows of the rotation matrix times v, rounded half up, clipped
   function automatic rot_word_type rotate_vector(input vec_word_type word);
      longint       w, x, y, z;
      longint       mat [3][3];
      longint       vec [3];
      longint       acc;
      longint       top_val;
      longint       bot_val;
      comp_type     axis [3];
      rot_word_type res;
      w = longint'(signed'(word.q.w));
      x = longint'(signed'(word.q.x));
      y = longint'(signed'(word.q.y));
      z = longint'(signed'(word.q.z));
      vec[0] = longint'(signed'(word.vx));
      vec[1] = longint'(signed'(word.vy));
      vec[2] = longint'(signed'(word.vz));
      mat[0][0] = w*w + x*x - y*y - z*z;
      mat[0][1] = 2 * (x*y - w*z);
      mat[0][2] = 2 * (x*z + w*y);
      mat[1][0] = 2 * (x*y + w*z);
      mat[1][1] = w*w - x*x + y*y - z*z;
      mat[1][2] = 2 * (y*z - w*x);
      mat[2][0] = 2 * (x*z - w*y);
      mat[2][1] = 2 * (y*z + w*x);
      mat[2][2] = w*w - x*x - y*y + z*z;
      top_val = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      bot_val = -top_val - 1;
      res.saturated = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         acc = mat[i][0] * vec[0] + mat[i][1] * vec[1] + mat[i][2] * vec[2];
         acc = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
         if (acc > top_val) begin
            acc = top_val;
            res.saturated = 1'b1;
         end
         if (acc < bot_val) begin
            acc = bot_val;
            res.saturated = 1'b1;
         end
         axis[i] = acc[DATA_WIDTH-1:0];
      end
      res.rot_x = axis[0];
      res.rot_y = axis[1];
      res.rot_z = axis[2];
      return res;
   endfunction

   function automatic vec_word_type make_word(input int w, input int x, input int y, input int z,
                                              input int vx, input int vy, input int vz);
      vec_word_type word;
      word.q.w = quat_comp_type'(w);
      word.q.x = quat_comp_type'(x);
      word.q.y = quat_comp_type'(y);
      word.q.z = quat_comp_type'(z);
      word.vx  = comp_type'(vx);
      word.vy  = comp_type'(vy);
      word.vz  = comp_type'(vz);
      return word;
   endfunction

   task automatic add_row(input vec_word_type word, input bit known,
                          input int ex, input int ey, input int ez, input bit es);
      table_row_type row;
      row.word            = word;
      row.known           = known;
      row.want.rot_x      = comp_type'(ex);
      row.want.rot_y      = comp_type'(ey);
      row.want.rot_z      = comp_type'(ez);
      row.want.saturated  = es;
      directed_rows.push_back(row);
   endtask

   // half near-unit quaternions, a quarter with components below one, a quarter anything at all
   function automatic vec_word_type draw_word();
      int           comp [4];
      int           vecs [3];
      int           sum_sq;
      int           kind;
      real          mag;
      vec_word_type word;
      kind = $urandom_range(99);
      for (int i = 0; i < 4; i++) begin
         comp[i] = int'($urandom_range(32767)) - 16384;
      end
      if (kind < 50) begin
         sum_sq = 0;
         for (int i = 0; i < 4; i++) begin
            sum_sq += (comp[i] / 4) * (comp[i] / 4);
         end
         if (sum_sq == 0) begin
            comp[0] = 16384;
         end else begin
            mag = $sqrt(real'(sum_sq));
            for (int i = 0; i < 4; i++) begin
               comp[i] = $rtoi(real'(comp[i] / 4) * 16384.0 / mag);
            end
         end
      end else if (kind >= 75) begin
         for (int i = 0; i < 4; i++) begin
            comp[i] = int'($urandom_range(65535)) - 32768;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(1) == 0) begin
            vecs[i] = int'($urandom_range(2000)) - 1000;
         end else begin
            vecs[i] = int'($urandom_range(65535)) - 32768;
         end
      end
      word = make_word(comp[0], comp[1], comp[2], comp[3], vecs[0], vecs[1], vecs[2]);
      return word;
   endfunction

   task automatic offer_word(input vec_word_type word);
      if (!steady_flow && $urandom_range(99) < 20) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.quat_w <= word.q.w;
      req_chan.quat_x <= word.q.x;
      req_chan.quat_y <= word.q.y;
      req_chan.quat_z <= word.q.z;
      req_chan.vec_x  <= word.vx;
      req_chan.vec_y  <= word.vy;
      req_chan.vec_z  <= word.vz;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin : response_pacing
      int unsigned hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_wanted && !stall_done) begin
            stall_done = 1'b1;
            hold_left = STALL_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady_flow || ($urandom_range(99) >= 20);
         end
      end
   end

   always @(posedge clock) begin : check_rotations
      rot_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rotations_due.size() == 0) begin
            $error("response word with nothing pending");
            failures++;
         end else begin
            want = rotations_due.pop_front();
            if (rsp_chan.rot_x !== want.rot_x) begin
               $error("rot_x: expected %0d, got %0d", want.rot_x, rsp_chan.rot_x);
               failures++;
            end
            if (rsp_chan.rot_y !== want.rot_y) begin
               $error("rot_y: expected %0d, got %0d", want.rot_y, rsp_chan.rot_y);
               failures++;
            end
            if (rsp_chan.rot_z !== want.rot_z) begin
               $error("rot_z: expected %0d, got %0d", want.rot_z, rsp_chan.rot_z);
               failures++;
            end
            if (rsp_chan.saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated, rsp_chan.saturated);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout with %0d words pending", rotations_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      vec_word_type word;
      failures       = 0;
      steady_flow    = 1'b0;
      stall_wanted   = 1'b0;
      stall_done     = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.quat_w = '0;
      req_chan.quat_x = '0;
      req_chan.quat_y = '0;
      req_chan.quat_z = '0;
      req_chan.vec_x  = '0;
      req_chan.vec_y  = '0;
      req_chan.vec_z  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // identity, zero and scaled quaternions
      add_row(make_word(16384, 0, 0, 0, 32767, -32768, 0), 1, 32767, -32768, 0, 0);
      add_row(make_word(16384, 0, 0, 0, -32768, -32768, -32768), 1, -32768, -32768, -32768, 0);
      add_row(make_word(0, 0, 0, 0, 32767, -32768, 12345), 1, 0, 0, 0, 0);
      add_row(make_word(-32768, 0, 0, 0, 100, -200, 8191), 1, 400, -800, 32764, 0);
      add_row(make_word(-32768, 0, 0, 0, 32767, -32768, 8192), 1, 32767, -32768, 32767, 1);
      // half turns about each axis, negating the most negative value clips
      add_row(make_word(0, 0, 0, 16384, 1000, -32768, -5), 1, -1000, 32767, -5, 1);
      add_row(make_word(0, 16384, 0, 0, 7, 32767, -32767), 1, 7, -32767, 32767, 0);
      add_row(make_word(0, 0, 16384, 0, -32768, 3, 0), 1, 32767, 3, 0, 1);
      // quarter turn about z with |q|^2 of two
      add_row(make_word(16384, 0, 0, 16384, 100, 200, -300), 1, -400, 200, -600, 0);
      // rounding of halves and quarters
      add_row(make_word(8192, 0, 0, 0, 2, -2, 1), 1, 1, 0, 0, 0);
      add_row(make_word(8192, 0, 0, 0, 6, -6, -3), 1, 2, -1, -1, 0);
      // extremes left to the predictor
      add_row(make_word(-32768, -32768, -32768, -32768, 32767, 32767, 32767), 0, 0, 0, 0, 0);
      add_row(make_word(32767, 32767, 32767, 32767, -32768, -32768, -32768), 0, 0, 0, 0, 0);
      add_row(make_word(32767, -32768, 32767, -32768, 32767, -32768, 1), 0, 0, 0, 0, 0);
      add_row(make_word(-1, -1, -1, -1, -1, -1, -1), 0, 0, 0, 0, 0);
      add_row(make_word(11585, 0, 11585, 0, 1, 1, 1), 0, 0, 0, 0, 0);
      add_row(make_word(8192, 8192, 8192, 8192, 12000, -7000, 3000), 0, 0, 0, 0, 0);
      add_row(make_word(1, 0, 0, 0, 32767, -32768, 16384), 0, 0, 0, 0, 0);

      foreach (directed_rows[i]) begin
         offer_word(directed_rows[i].word);
         if (directed_rows[i].known) begin
            rotations_due.push_back(directed_rows[i].want);
         end else begin
            rotations_due.push_back(rotate_vector(directed_rows[i].word));
         end
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 300) begin
            stall_wanted = 1'b1;
         end
         steady_flow = (n >= 800 && n < 1200);
         word = draw_word();
         offer_word(word);
         rotations_due.push_back(rotate_vector(word));
      end
      req_chan.valid <= 1'b0;
      steady_flow = 1'b0;

      while (rotations_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
